// ===== rtl/llcxid_pkg.sv =====
// Shared types, codes and range limits for the LLC XID field parser.
`default_nettype none
package llcxid_pkg;

  typedef enum logic [1:0] {
    KIND_FIXED     = 2'd0,
    KIND_VAR_BYTE  = 2'd1,
    KIND_VAR_EMPTY = 2'd2,
    KIND_STATUS    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_MANY    = 3'd1,
    ST_UNKNOWN     = 3'd2,
    ST_SHORT       = 3'd3,
    ST_BAD_LENGTH  = 3'd4,
    ST_OUT_OF_RANGE = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_EXTLEN  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DRAIN   = 4'b1000
  } phase_e;

  localparam logic [4:0] VarType       = 5'd11;
  localparam logic [7:0] FieldLimitRst = 8'd16;
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrW        = $clog2(QDepth);

  typedef struct packed {
    kind_e       result_kind;
    logic [4:0]  field_type;
    logic [7:0]  field_length;
    logic [31:0] field_value;
    logic [7:0]  payload_offset;
    logic [7:0]  field_number;
    status_e     status;
    logic        end_of_message;
  } res_t;

  // up to two results per item, first slot always filled first
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  localparam logic [31:0] LimMin [16] = '{
    32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd140, 32'd140, 32'd9,
    32'd9, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0
  };
  localparam logic [31:0] LimMax [16] = '{
    32'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4095, 32'd15, 32'd1520, 32'd1520,
    32'd24320, 32'd24320, 32'd255, 32'd255, 32'd0, 32'd0, 32'hFFFF_FFFF,
    32'd255, 32'hFFFF_FFFF
  };

  // mD and mU (types 7 and 8) also take zero
  function automatic logic value_ok(logic [3:0] t, logic [31:0] v);
    logic zero_ok;
    zero_ok = (t == 4'd7 || t == 4'd8) && (v == 32'd0);
    return ((v >= LimMin[t]) && (v <= LimMax[t])) || zero_ok;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/llcxid_if.sv =====
// Valid/ready channel interfaces for parser bytes and results.
`default_nettype none
interface llcxid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface llcxid_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [4:0]  field_type;
  logic [7:0]  field_length;
  logic [31:0] field_value;
  logic [7:0]  payload_offset;
  logic [7:0]  field_number;
  logic [2:0]  status;
  logic        end_of_message;
  modport source (output valid, output result_kind, output field_type,
                  output field_length, output field_value, output payload_offset,
                  output field_number, output status, output end_of_message,
                  input ready);
  modport sink   (input valid, input result_kind, input field_type,
                  input field_length, input field_value, input payload_offset,
                  input field_number, input status, input end_of_message,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/llc_xid_field_parser.sv =====
// Top level of the LLC XID field parser.
//
//  channel  dir  handshake              carries
//  in_i     in   valid/ready            data_byte, last_byte
//  out_o    out  valid/ready            one result per item moved
//  cfg      in   cfg_we_i, cfg_wdata_i  field_limit
//
// Each byte is parsed in the cycle it is taken and its results land in a
// four-entry result queue; the output is read from that queue's registers.
// One byte a cycle while there is room; a byte that closes a field on the
// last byte of a message yields two results, drained one a cycle if ready.
// Input stalls only when the queue holds more than two results.
// Reset: field_limit 16, empty queue, parser waiting for a header.
`default_nettype none
module llc_xid_field_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  llcxid_in_if.sink       in_i,
  llcxid_out_if.source    out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);
  import llcxid_pkg::*;

  push_t push;
  res_t  head;
  logic  room;
  logic  accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  llcxid_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push)
  );

  llcxid_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.result_kind    = head.result_kind;
  assign out_o.field_type     = head.field_type;
  assign out_o.field_length   = head.field_length;
  assign out_o.field_value    = head.field_value;
  assign out_o.payload_offset = head.payload_offset;
  assign out_o.field_number   = head.field_number;
  assign out_o.status         = head.status;
  assign out_o.end_of_message = head.end_of_message;

endmodule
`default_nettype wire

// ===== rtl/llcxid_core.sv =====
// Per-byte XID parse step: message state, field limit register, result build.
`default_nettype none
module llcxid_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  output llcxid_pkg::push_t      push_o
);
  import llcxid_pkg::*;

  phase_e      ph_q, ph_d;
  logic [4:0]  typ_q, typ_d;
  logic [1:0]  lhb_q, lhb_d;
  logic [7:0]  bl_q, bl_d;
  logic [7:0]  decl_q, decl_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  fs_q, fs_d;
  status_e     err_q, err_d;
  logic [7:0]  limit_q;

  always_comb begin
    logic       start;
    logic [7:0] start_len;
    logic       fin;
    logic       fld_v;
    res_t       fld;
    res_t       stat;

    ph_d   = ph_q;
    typ_d  = typ_q;
    lhb_d  = lhb_q;
    bl_d   = bl_q;
    decl_d = decl_q;
    acc_d  = acc_q;
    fs_d   = fs_q;
    err_d  = err_q;
    start  = 1'b0;
    start_len = 8'd0;
    fin    = 1'b0;
    fld_v  = 1'b0;
    fld    = '0;
    stat   = '0;

    unique case (ph_q)
      PH_HEADER: begin
        if (fs_q >= limit_q) begin
          err_d = ST_TOO_MANY;
          ph_d  = PH_DRAIN;
        end else begin
          fs_d  = fs_q + 8'd1;
          typ_d = data_byte_i[6:2];
          if (data_byte_i[6]) begin
            err_d = ST_UNKNOWN;
            ph_d  = PH_DRAIN;
          end else if (data_byte_i[7]) begin
            if (last_byte_i) begin
              err_d = ST_SHORT;
              ph_d  = PH_DRAIN;
            end else begin
              lhb_d = data_byte_i[1:0];
              ph_d  = PH_EXTLEN;
            end
          end else begin
            start     = 1'b1;
            start_len = {6'd0, data_byte_i[1:0]};
          end
        end
      end
      PH_EXTLEN: begin
        start     = 1'b1;
        start_len = {lhb_q, data_byte_i[7:2]};
      end
      PH_PAYLOAD: begin
        if (typ_q == VarType) begin
          fld_v              = 1'b1;
          fld.result_kind    = KIND_VAR_BYTE;
          fld.field_type     = typ_q;
          fld.field_length   = decl_q;
          fld.field_value    = {24'd0, data_byte_i};
          fld.payload_offset = decl_q - bl_q;
          fld.field_number   = fs_q - 8'd1;
        end
        acc_d = {acc_q[23:0], data_byte_i};
        bl_d  = bl_q - 8'd1;
        if (bl_d == 8'd0) begin
          fin = 1'b1;
        end else if (last_byte_i) begin
          err_d = ST_SHORT;
          ph_d  = PH_DRAIN;
        end
      end
      PH_DRAIN: ;
      default: ;
    endcase

    if (start) begin
      decl_d = start_len;
      bl_d   = start_len;
      acc_d  = 32'd0;
      if (start_len == 8'd0) begin
        fin = 1'b1;
      end else if (last_byte_i) begin
        err_d = ST_SHORT;
        ph_d  = PH_DRAIN;
      end else begin
        ph_d = PH_PAYLOAD;
      end
    end

    if (fin) begin
      ph_d = PH_HEADER;
      fld.field_type   = typ_d;
      fld.field_number = fs_d - 8'd1;
      if (typ_d == VarType) begin
        // a non-empty L3 field has already given out its bytes
        if (decl_d == 8'd0) begin
          fld_v           = 1'b1;
          fld.result_kind = KIND_VAR_EMPTY;
        end
      end else if (decl_d != 8'd0 && decl_d != 8'd1 && decl_d != 8'd2 &&
                   decl_d != 8'd4) begin
        err_d = ST_BAD_LENGTH;
        ph_d  = PH_DRAIN;
      end else if (!value_ok(typ_d[3:0], acc_d)) begin
        err_d = ST_OUT_OF_RANGE;
        ph_d  = PH_DRAIN;
      end else begin
        fld_v            = 1'b1;
        fld.result_kind  = KIND_FIXED;
        fld.field_length = decl_d;
        fld.field_value  = acc_d;
      end
    end

    stat.result_kind    = KIND_STATUS;
    stat.field_number   = fs_d;
    stat.status         = err_d;
    stat.end_of_message = 1'b1;

    if (last_byte_i) begin
      ph_d   = PH_HEADER;
      typ_d  = 5'd0;
      lhb_d  = 2'd0;
      bl_d   = 8'd0;
      decl_d = 8'd0;
      acc_d  = 32'd0;
      fs_d   = 8'd0;
      err_d  = ST_OK;
    end

    push_o.v0 = accept_i && (fld_v || last_byte_i);
    push_o.v1 = accept_i && fld_v && last_byte_i;
    push_o.r0 = fld_v ? fld : stat;
    push_o.r1 = stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_HEADER;
      typ_q   <= 5'd0;
      lhb_q   <= 2'd0;
      bl_q    <= 8'd0;
      decl_q  <= 8'd0;
      acc_q   <= 32'd0;
      fs_q    <= 8'd0;
      err_q   <= ST_OK;
      limit_q <= FieldLimitRst;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        ph_q   <= ph_d;
        typ_q  <= typ_d;
        lhb_q  <= lhb_d;
        bl_q   <= bl_d;
        decl_q <= decl_d;
        acc_q  <= acc_d;
        fs_q   <= fs_d;
        err_q  <= err_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/llcxid_rq.sv =====
// Result queue: takes up to two results a cycle, hands out one when the sink is ready.
`default_nettype none
module llcxid_rq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire llcxid_pkg::push_t  push_i,
  output logic                    room_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output llcxid_pkg::res_t        head_o
);
  import llcxid_pkg::*;

  res_t                mem_q [QDepth];
  logic [QPtrW-1:0]    wr_q, rd_q;
  logic [QPtrW:0]      cnt_q;
  logic                pop;
  logic [QPtrW:0]      n_push;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  // room for a two-result item regardless of the sink
  assign room_o  = (cnt_q <= (QPtrW+1)'(QDepth - 2));
  assign n_push  = (QPtrW+1)'(push_i.v0) + (QPtrW+1)'(push_i.v1);

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_q + QPtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push[QPtrW-1:0];
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_q + n_push - (QPtrW+1)'(pop);
    end
  end

endmodule
`default_nettype wire
